### hdl/wtt_pkg.sv
package wtt_pkg;

	localparam int MAX_TAB_DEF = 8;
	localparam int MAX_RESULTS = 10;

	// character codes
	localparam logic [7:0] CH_HYPHEN = 8'h2D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// configuration register indexes
	localparam logic [1:0] REG_HYPHEN_BREAK    = 2'd0;
	localparam logic [1:0] REG_COLLAPSE_SPACES = 2'd1;
	localparam logic [1:0] REG_TAB_SPACES      = 2'd2;

	typedef enum logic [2:0] {
		KIND_CHUNK   = 3'd0,
		KIND_SPACE   = 3'd1,
		KIND_NEWLINE = 3'd2,
		KIND_PARA    = 3'd3,
		KIND_END     = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		MODE_INITIAL = 2'd0,
		MODE_WORD    = 2'd1,
		MODE_SPACE   = 2'd2
	} mode_t;

	typedef struct packed {
		logic       hyphen_break;
		logic       collapse_spaces;
		logic [3:0] tab_spaces;
	} cfg_t;

	typedef struct packed {
		mode_t mode;
		logic  chunk_open;
		logic  prev_alpha;
		logic  nl_pend;
		logic  run_open;
	} tok_st_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       first;
		logic       last;
	} res_t;

endpackage

### hdl/wtt_ifs.sv
interface wtt_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] char_in;

	modport source (output valid, output command, output char_in, input ready);
	modport sink (input valid, input command, input char_in, output ready);
endinterface

interface wtt_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] token_kind;
	logic [7:0] char_out;
	logic       token_first;
	logic       last;

	modport source (output valid, output token_kind, output char_out, output token_first,
		output last, input ready);
	modport sink (input valid, input token_kind, input char_out, input token_first,
		input last, output ready);
endinterface

interface wtt_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [3:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/wtt_cfg.sv
module wtt_cfg (
	input  logic          clk,
	input  logic          arst_n,
	wtt_cfg_if.sink       cfg,
	output wtt_pkg::cfg_t regs
);
	import wtt_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.hyphen_break    <= 1'b1;
			regs_q.collapse_spaces <= 1'b0;
			regs_q.tab_spaces      <= 4'd8;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_HYPHEN_BREAK:    regs_q.hyphen_break <= cfg.data[0];
				REG_COLLAPSE_SPACES: regs_q.collapse_spaces <= cfg.data[0];
				REG_TAB_SPACES:      regs_q.tab_spaces <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

### hdl/wtt_core.sv
module wtt_core #(
	parameter int MAX_TAB = wtt_pkg::MAX_TAB_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	wtt_in_if.sink        chars,
	input  wtt_pkg::cfg_t cfg,
	input  logic          out_free,
	output logic          emit_valid,
	output wtt_pkg::res_t res
);
	import wtt_pkg::*;

	localparam int RW = $clog2(MAX_TAB + 1);
	localparam int CW = $clog2(MAX_RESULTS);
	localparam tok_st_t ST_CLEAR = '{mode: MODE_INITIAL, chunk_open: 1'b0,
		prev_alpha: 1'b0, nl_pend: 1'b0, run_open: 1'b0};

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	logic          vld_s1;
	logic          cmd_s1;
	logic [7:0]    ch_s1;
	logic [RW-1:0] rem_s1;
	logic [CW-1:0] cnt_s1;
	tok_st_t       st_q;
	tok_st_t       st_nx;
	tok_st_t       sp;
	tok_st_t       wd;
	logic          flush;
	logic          emit;
	logic          done;
	logic          rem_dec;
	logic          step_en;
	logic [RW-1:0] tab_n;

	always_comb begin
		if (int'(cfg.tab_spaces) > MAX_TAB) begin
			tab_n = RW'(MAX_TAB);
		end else begin
			tab_n = RW'(cfg.tab_spaces);
		end
	end

	// one result at most per step; an item steps until done
	always_comb begin
		st_nx     = st_q;
		emit      = 1'b0;
		done      = 1'b0;
		rem_dec   = 1'b0;
		res.kind  = KIND_CHUNK;
		res.ch    = '0;
		res.first = 1'b1;
		sp        = st_q;
		if (st_q.mode != MODE_SPACE) begin
			sp      = ST_CLEAR;
			sp.mode = MODE_SPACE;
		end
		wd = st_q;
		if (st_q.mode != MODE_WORD) begin
			wd      = ST_CLEAR;
			wd.mode = MODE_WORD;
		end
		flush = (st_q.mode == MODE_SPACE) && st_q.nl_pend;

		if (cmd_s1) begin
			emit = 1'b1;
			if (flush) begin
				res.kind       = KIND_NEWLINE;
				st_nx.nl_pend  = 1'b0;
				st_nx.run_open = 1'b0;
			end else begin
				res.kind = KIND_END;
				done     = 1'b1;
				st_nx    = ST_CLEAR;
			end
		end else begin
			case (ch_s1) inside
				CH_CR, CH_FF: begin
					done = 1'b1;
				end
				CH_LF, CH_VT: begin
					done  = 1'b1;
					st_nx = sp;
					if (sp.nl_pend) begin
						emit           = 1'b1;
						res.kind       = KIND_PARA;
						st_nx.nl_pend  = 1'b0;
						st_nx.run_open = 1'b0;
					end else begin
						st_nx.nl_pend = 1'b1;
					end
				end
				CH_SPACE, CH_TAB: begin
					if (ch_s1 == CH_TAB && rem_s1 == '0) begin
						done = 1'b1;
					end else begin
						st_nx = sp;
						if (sp.nl_pend) begin
							emit           = 1'b1;
							res.kind       = KIND_NEWLINE;
							st_nx.nl_pend  = 1'b0;
							st_nx.run_open = 1'b0;
						end else begin
							res.kind       = KIND_SPACE;
							res.ch         = CH_SPACE;
							res.first      = !sp.run_open;
							emit           = !cfg.collapse_spaces || !sp.run_open;
							st_nx.run_open = 1'b1;
							// collapsed tab: the remaining spaces change nothing
							done = (ch_s1 != CH_TAB) || cfg.collapse_spaces
								|| (rem_s1 == RW'(1));
							rem_dec = 1'b1;
						end
					end
				end
				default: begin
					emit = 1'b1;
					if (flush) begin
						res.kind       = KIND_NEWLINE;
						st_nx.nl_pend  = 1'b0;
						st_nx.run_open = 1'b0;
					end else begin
						res.kind  = KIND_CHUNK;
						res.ch    = ch_s1;
						res.first = !wd.chunk_open;
						done      = 1'b1;
						st_nx     = wd;
						if (cfg.hyphen_break && ch_s1 == CH_HYPHEN && wd.chunk_open
							&& wd.prev_alpha) begin
							st_nx.chunk_open = 1'b0;
							st_nx.prev_alpha = 1'b0;
						end else begin
							st_nx.chunk_open = 1'b1;
							st_nx.prev_alpha = is_letter(ch_s1);
						end
					end
				end
			endcase
		end

		// results past the limit are dropped; later tab spaces leave state as is
		if (emit && cnt_s1 == CW'(MAX_RESULTS - 1)) begin
			done = 1'b1;
		end
		res.last = done;
	end

	assign step_en     = vld_s1 && out_free;
	assign emit_valid  = step_en && emit;
	assign chars.ready = !vld_s1 || (step_en && done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			rem_s1 <= '0;
			cnt_s1 <= '0;
			st_q   <= ST_CLEAR;
		end else begin
			if (chars.valid && chars.ready) begin
				vld_s1 <= 1'b1;
				rem_s1 <= tab_n;
				cnt_s1 <= '0;
			end else if (step_en && done) begin
				vld_s1 <= 1'b0;
			end else if (step_en) begin
				if (emit) begin
					cnt_s1 <= cnt_s1 + CW'(1);
				end
				if (rem_dec) begin
					rem_s1 <= rem_s1 - RW'(1);
				end
			end
			if (step_en) begin
				st_q <= st_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			cmd_s1 <= chars.command;
			ch_s1  <= chars.char_in;
		end
	end

`ifndef ASSERT_OFF
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_valid && res.kind == KIND_END) |=> (st_q.mode == MODE_INITIAL && !st_q.nl_pend
			&& !st_q.chunk_open && !st_q.run_open))
		else $error("state not cleared after end of input");
	a_nl_in_space: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.nl_pend |-> st_q.mode == MODE_SPACE)
		else $error("held newline outside whitespace");
	a_chunk_in_word: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.chunk_open |-> st_q.mode == MODE_WORD)
		else $error("open chunk outside chunk text");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> int'(cnt_s1) < MAX_RESULTS)
		else $error("result count past limit");
`endif

endmodule

### hdl/wtt_out.sv
module wtt_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  wtt_pkg::res_t res,
	output logic          free,
	wtt_out_if.source     tokens
);
	import wtt_pkg::*;

	logic valid_q;
	res_t res_q;

	assign free               = !valid_q || tokens.ready;
	assign tokens.valid       = valid_q;
	assign tokens.token_kind  = res_q.kind;
	assign tokens.char_out    = res_q.ch;
	assign tokens.token_first = res_q.first;
	assign tokens.last        = res_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (tokens.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

### hdl/wrap_text_tokenizer.sv
// channel  role    payload
// chars    sink    command, char_in
// tokens   source  token_kind, char_out, token_first, last
// cfg      sink    index, data (0 hyphen_break, 1 collapse_spaces, 2 tab_spaces)
//
// an item takes one step per result it yields, one step if it yields none;
// a tab takes up to min(tab_spaces, MAX_TAB) + 1 steps in the single step unit
// results show the cycle after their step; one byte per cycle unless stalled
// reset sets state and config to defaults, no clearing pass; held data is not reset
// tokens.ready low with a result held keeps it and pauses the step unit
// chars.ready is low while the held item still has results to produce or is stalled
module wrap_text_tokenizer #(
	parameter int MAX_TAB = wtt_pkg::MAX_TAB_DEF
) (
	input logic       clk,
	input logic       arst_n,
	wtt_in_if.sink    chars,
	wtt_out_if.source tokens,
	wtt_cfg_if.sink   cfg
);
	import wtt_pkg::*;

	cfg_t regs;
	res_t res;
	logic emit_valid;
	logic out_free;

	wtt_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	wtt_core #(
		.MAX_TAB (MAX_TAB)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.cfg        (regs),
		.out_free   (out_free),
		.emit_valid (emit_valid),
		.res        (res)
	);

	wtt_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (emit_valid),
		.res    (res),
		.free   (out_free),
		.tokens (tokens)
	);

endmodule
